[hw/rtl/itoar_pkg.sv]
// itoar_pkg: shared constants, command/status structs and the digit-to-ascii helper
// for the integer to ascii radix converter; no dependencies

package itoar_pkg;

  // default parameter values
  localparam int VALUE_BITS_DEF = 32;
  localparam int MAX_DIGITS_DEF = 32;

  // field widths fixed by the interface
  localparam int RADIX_W = 6;
  localparam int CHAR_W  = 8;

  // quotient bits produced per divider cycle
  localparam int CHUNK = 8;

  // radix limits
  localparam logic [RADIX_W-1:0] MIN_RADIX = 6'd2;
  localparam logic [RADIX_W-1:0] MAX_RADIX = 6'd36;
  localparam logic [RADIX_W-1:0] DEC_RADIX = 6'd10;
  localparam logic [RADIX_W-1:0] DIGIT_NINE = 6'd9;
  localparam logic [RADIX_W-1:0] DIGIT_TEN  = 6'd10;

  // ascii codes
  localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_A     = 8'h61;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;

  // controller to datapath commands
  typedef struct packed {
    logic load;   // transaction accepted
    logic div;    // one divider cycle
    logic sign;   // emit the leading minus
    logic rd;     // read one stored digit for output
  } itoar_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic in_bad;     // radix on the input ports is out of range
    logic step_last;  // current divider cycle finishes a digit
    logic div_done;   // no more digits after this one
    logic neg;        // leading minus due
    logic rd_zero;    // read pointer at the least significant digit
    logic pend;       // a digit read is in flight to the output
  } itoar_sts_t;

  function automatic logic [CHAR_W-1:0] char_of_digit(input logic [RADIX_W-1:0] d);
    logic [CHAR_W-1:0] dx;
    dx = {{(CHAR_W-RADIX_W){1'b0}}, d};
    if (d > DIGIT_NINE) begin
      return dx - {{(CHAR_W-RADIX_W){1'b0}}, DIGIT_TEN} + CH_A;
    end
    return dx + CH_ZERO;
  endfunction

endpackage

[hw/rtl/itoar_ctrl.sv]
// itoar_ctrl: sequencing state machine of the integer to ascii radix converter
// depends on itoar_pkg

module itoar_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  itoar_pkg::itoar_sts_t sts,
  output itoar_pkg::itoar_cmd_t cmd
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_DIV  = 4'b0010,
    ST_SIGN = 4'b0100,
    ST_OUT  = 4'b1000
  } itoar_state_t;

  itoar_state_t state_r, state_nxt;

  assign busy = (state_r != ST_IDLE) || sts.pend;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        cmd.load = start && !busy;
        if (start && !busy && !sts.in_bad) begin
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd.div = 1'b1;
        if (sts.step_last && sts.div_done) begin
          state_nxt = sts.neg ? ST_SIGN : ST_OUT;
        end
      end
      ST_SIGN: begin
        cmd.sign  = 1'b1;
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        cmd.rd = 1'b1;
        if (sts.rd_zero) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

[hw/rtl/itoar_dp.sv]
// itoar_dp: magnitude register, chunked restoring divider, digit store and output registers
// depends on itoar_pkg

module itoar_dp #(
  parameter int VALUE_BITS = itoar_pkg::VALUE_BITS_DEF,
  parameter int MAX_DIGITS = itoar_pkg::MAX_DIGITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic signed [VALUE_BITS-1:0]         in_value,
  input  logic [itoar_pkg::RADIX_W-1:0]        in_radix,
  input  itoar_pkg::itoar_cmd_t                cmd,
  output itoar_pkg::itoar_sts_t                sts,
  output logic                                 out_valid,
  output logic [itoar_pkg::CHAR_W-1:0]         out_char_code,
  output logic                                 out_last,
  output logic                                 out_bad_radix
);

  localparam int CHUNK    = itoar_pkg::CHUNK;
  localparam int RADIX_W  = itoar_pkg::RADIX_W;
  localparam int CHAR_W   = itoar_pkg::CHAR_W;
  localparam int STEPS    = (VALUE_BITS + CHUNK - 1) / CHUNK;
  localparam int PAD_BITS = STEPS * CHUNK;
  localparam int STEP_W   = (STEPS > 1) ? $clog2(STEPS) : 1;
  localparam int CNT_W    = $clog2(MAX_DIGITS + 1);
  localparam int IDX_W    = $clog2(MAX_DIGITS);

  logic [PAD_BITS-1:0]     quo_r;
  logic [RADIX_W-1:0]      rem_r;
  logic [RADIX_W-1:0]      radix_r;
  logic                    neg_r;
  logic [STEP_W-1:0]       step_r;
  logic [CNT_W-1:0]        cnt_r;
  logic [IDX_W-1:0]        rd_idx_r;
  logic [RADIX_W-1:0]      digit_mem [MAX_DIGITS];
  logic [RADIX_W-1:0]      rd_data_r;
  logic                    pend_r;
  logic                    pend_last_r;
  logic                    out_valid_r;
  logic [CHAR_W-1:0]       out_char_r;
  logic                    out_last_r;
  logic                    out_bad_r;

  logic [VALUE_BITS-1:0]   val_u;
  logic                    in_bad;
  logic                    in_neg;
  logic [VALUE_BITS-1:0]   mag;
  logic [CHUNK-1:0]        qbits;
  logic [RADIX_W-1:0]      rem_nxt;
  logic [PAD_BITS+CHUNK-1:0] quo_sh;
  logic [PAD_BITS-1:0]     quo_nxt;
  logic [CNT_W-1:0]        cnt_inc;
  logic [CNT_W-1:0]        cap;
  logic                    step_last;

  assign val_u  = $unsigned(in_value);
  assign in_bad = (in_radix < itoar_pkg::MIN_RADIX) || (in_radix > itoar_pkg::MAX_RADIX);
  assign in_neg = (in_radix == itoar_pkg::DEC_RADIX) && val_u[VALUE_BITS-1];
  assign mag    = in_neg ? (~val_u + VALUE_BITS'(1)) : val_u;

  // restoring division, one chunk of quotient bits per cycle
  always_comb begin
    logic [RADIX_W:0]   t;
    logic [RADIX_W-1:0] r;
    logic [CHUNK-1:0]   top;
    r   = rem_r;
    top = quo_r[PAD_BITS-1 -: CHUNK];
    for (int i = CHUNK - 1; i >= 0; i--) begin
      t = {r, top[i]};
      if (t >= {1'b0, radix_r}) begin
        t        = t - {1'b0, radix_r};
        qbits[i] = 1'b1;
      end else begin
        qbits[i] = 1'b0;
      end
      r = t[RADIX_W-1:0];
    end
    rem_nxt = r;
  end

  assign quo_sh    = {quo_r, qbits};
  assign quo_nxt   = quo_sh[PAD_BITS-1:0];
  assign cnt_inc   = cnt_r + CNT_W'(1);
  assign cap       = CNT_W'(MAX_DIGITS) - CNT_W'(neg_r);
  assign step_last = (step_r == STEP_W'(STEPS - 1));

  always_comb begin
    sts           = '0;
    sts.in_bad    = in_bad;
    sts.step_last = step_last;
    sts.div_done  = (quo_nxt == '0) || (cnt_inc >= cap);
    sts.neg       = neg_r;
    sts.rd_zero   = (rd_idx_r == '0);
    sts.pend      = pend_r;
  end

  // working registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      quo_r   <= PAD_BITS'(mag);
      rem_r   <= '0;
      radix_r <= in_radix;
    end else if (cmd.div) begin
      quo_r <= quo_nxt;
      rem_r <= step_last ? '0 : rem_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      neg_r    <= 1'b0;
      step_r   <= '0;
      cnt_r    <= '0;
      rd_idx_r <= '0;
    end else if (cmd.load) begin
      neg_r  <= in_neg;
      step_r <= '0;
      cnt_r  <= '0;
    end else if (cmd.div) begin
      if (step_last) begin
        step_r   <= '0;
        cnt_r    <= cnt_inc;
        rd_idx_r <= cnt_r[IDX_W-1:0];
      end else begin
        step_r <= step_r + STEP_W'(1);
      end
    end else if (cmd.rd) begin
      rd_idx_r <= rd_idx_r - IDX_W'(1);
    end
  end

  // digit store, least significant first
  always_ff @(posedge clk) begin
    if (cmd.div && step_last) begin
      digit_mem[cnt_r[IDX_W-1:0]] <= rem_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd) begin
      rd_data_r <= digit_mem[rd_idx_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r      <= 1'b0;
      pend_last_r <= 1'b0;
    end else begin
      pend_r      <= cmd.rd;
      pend_last_r <= cmd.rd && (rd_idx_r == '0);
    end
  end

  // output registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= pend_r || cmd.sign || (cmd.load && in_bad);
    end
  end

  always_ff @(posedge clk) begin
    if (pend_r) begin
      out_char_r <= itoar_pkg::char_of_digit(rd_data_r);
      out_last_r <= pend_last_r;
      out_bad_r  <= 1'b0;
    end else if (cmd.sign) begin
      out_char_r <= itoar_pkg::CH_MINUS;
      out_last_r <= 1'b0;
      out_bad_r  <= 1'b0;
    end else if (cmd.load && in_bad) begin
      out_char_r <= itoar_pkg::CH_NUL;
      out_last_r <= 1'b1;
      out_bad_r  <= 1'b1;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_char_code = out_char_r;
  assign out_last      = out_last_r;
  assign out_bad_radix = out_bad_r;

`ifndef NO_ASSERTIONS
  // a new transaction never lands on a digit still in flight to the output
  a_no_load_on_pend: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |-> !cmd.load)
    else $error("transaction accepted while a digit is in flight");

  // the divider only runs with a legal radix
  a_div_radix_ok: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div |-> (radix_r >= itoar_pkg::MIN_RADIX && radix_r <= itoar_pkg::MAX_RADIX))
    else $error("divider running with an illegal radix");

  // every digit read hits an entry written by this conversion
  a_rd_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rd |-> (CNT_W'(rd_idx_r) < cnt_r))
    else $error("digit read beyond the stored count");

  // the digit count never exceeds its capacity
  a_cnt_cap: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div && step_last |-> (cnt_r < cap))
    else $error("digit store overflow");
`endif

endmodule

[hw/rtl/integer_to_ascii_radix_top.sv]
// integer_to_ascii_radix_top: top level of the integer to ascii radix converter
// depends on itoar_pkg, itoar_ctrl and itoar_dp

// Converts one VALUE_BITS-bit integer to its text form in radix 2..36 and sends
// the ascii characters out most significant first, with out_last on the final
// one; digits above 9 use 'a'..'z', zero gives a single '0', and a negative value
// is shown with a leading '-' only in radix 10 (every other radix reads the value
// as an unsigned bit pattern). A transaction is accepted when start is high and
// busy is low. The receiver cannot stall: each character is on the out_ ports for
// exactly one cycle with out_valid high. A radix outside 2..36 gives one result
// with char code 0, out_last and out_bad_radix set, in the cycle after acceptance,
// and the block takes a new transaction in that same cycle.
// For a legal radix each digit is one full pass of the shared restoring divider
// over the zero-padded magnitude, which settles eight quotient bits per cycle; the
// digits then stream out back to back, each read from the digit store into a
// register and then loaded into the output registers. A leading minus goes out
// from the sign state after division ends, ahead of the digit reads, with a gap
// before the first digit. busy drops with the last character on the ports.
module integer_to_ascii_radix_top #(
  parameter int VALUE_BITS = itoar_pkg::VALUE_BITS_DEF,
  parameter int MAX_DIGITS = itoar_pkg::MAX_DIGITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // input transaction
  input  logic                          start,
  output logic                          busy,
  input  logic signed [VALUE_BITS-1:0]  in_value,
  input  logic [itoar_pkg::RADIX_W-1:0] in_radix,
  // character stream
  output logic                          out_valid,
  output logic [itoar_pkg::CHAR_W-1:0]  out_char_code,
  output logic                          out_last,
  output logic                          out_bad_radix
);

  itoar_pkg::itoar_cmd_t cmd;
  itoar_pkg::itoar_sts_t sts;

  // sequencer: idle, divide, optional sign, stream digits
  itoar_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .cmd   (cmd)
  );

  // magnitude, divider, digit store and output registers
  itoar_dp #(
    .VALUE_BITS (VALUE_BITS),
    .MAX_DIGITS (MAX_DIGITS)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_value      (in_value),
    .in_radix      (in_radix),
    .cmd           (cmd),
    .sts           (sts),
    .out_valid     (out_valid),
    .out_char_code (out_char_code),
    .out_last      (out_last),
    .out_bad_radix (out_bad_radix)
  );

endmodule

[bench/tb_top.sv]
// tb_top: self-checking bench for integer_to_ascii_radix_top, conversions in radix 2..36
// plus out-of-range radix errors, each character checked against an in-bench predictor
// depends on itoar_pkg and integer_to_ascii_radix_top
`timescale 1ns / 100ps

module tb_top;

  // one pending conversion request
  typedef struct {
    logic [31:0]                   value;
    logic [itoar_pkg::RADIX_W-1:0] radix;
    logic                          hold_off;  // wait for the block to drain before sending
  } conv_req_t;

  // one expected character beat
  typedef struct packed {
    logic [itoar_pkg::CHAR_W-1:0] code;
    logic                         last;
    logic                         bad;
  } char_beat_t;

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          start = 1'b0;
  logic signed [31:0]            in_value = '0;
  logic [itoar_pkg::RADIX_W-1:0] in_radix = '0;
  logic                          busy;
  logic                          out_valid;
  logic [itoar_pkg::CHAR_W-1:0]  out_char_code;
  logic                          out_last;
  logic                          out_bad_radix;

  conv_req_t  conv_q[$];   // requests not yet driven
  char_beat_t text_q[$];   // characters still to come, oldest first

  logic item_taken = 1'b0; // the request on the ports went in at the last rising edge
  int   burst_left = 4;
  int   gap_left = 0;

  int n_conv = 0;
  int n_chars = 0;
  int n_bad = 0;
  int n_neg = 0;
  int n_fail = 0;

  integer_to_ascii_radix_top i_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_value      (in_value),
    .in_radix      (in_radix),
    .out_valid     (out_valid),
    .out_char_code (out_char_code),
    .out_last      (out_last),
    .out_bad_radix (out_bad_radix)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // expected text of one conversion, appended to text_q
  function automatic void predict_text(input logic [31:0] val,
                                       input logic [itoar_pkg::RADIX_W-1:0] base);
    logic [31:0]                   mag;
    logic [itoar_pkg::RADIX_W-1:0] digits[$];
    logic                          minus;
    int                            cap;
    int                            total;
    int                            n;
    char_beat_t                    beat;
    // out-of-range radix: a single flagged beat, nothing else
    if (base < itoar_pkg::MIN_RADIX || base > itoar_pkg::MAX_RADIX) begin
      beat.code = itoar_pkg::CH_NUL;
      beat.last = 1'b1;
      beat.bad  = 1'b1;
      text_q.push_back(beat);
      n_bad++;
      return;
    end
    // sign only counts in base ten, elsewhere the pattern is unsigned
    minus = (base == itoar_pkg::DEC_RADIX) && val[31];
    mag   = minus ? (32'd0 - val) : val;
    cap   = minus ? itoar_pkg::MAX_DIGITS_DEF - 1 : itoar_pkg::MAX_DIGITS_DEF;
    if (minus) n_neg++;
    if (mag == 32'd0) digits.push_front('0);
    // digits collected least significant first, stored most significant first
    while (mag != 32'd0 && digits.size() < cap) begin
      digits.push_front(itoar_pkg::RADIX_W'(mag % base));
      mag = mag / base;
    end
    total = digits.size() + (minus ? 1 : 0);
    n = 0;
    beat.bad = 1'b0;
    if (minus) begin
      n++;
      beat.code = itoar_pkg::CH_MINUS;
      beat.last = (n == total);
      text_q.push_back(beat);
    end
    foreach (digits[k]) begin
      n++;
      beat.code = (digits[k] > itoar_pkg::DIGIT_NINE)
                ? itoar_pkg::CH_A + itoar_pkg::CHAR_W'(digits[k] - itoar_pkg::DIGIT_TEN)
                : itoar_pkg::CH_ZERO + itoar_pkg::CHAR_W'(digits[k]);
      beat.last = (n == total);
      text_q.push_back(beat);
    end
  endfunction

  // driver: bursts of requests with random gaps, inputs move on the falling edge
  always @(negedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else if (start && !item_taken) begin
      // request still waiting for acceptance, hold everything
    end else if (gap_left > 0) begin
      gap_left = gap_left - 1;
      start    <= 1'b0;
      in_value <= $urandom;
      in_radix <= itoar_pkg::RADIX_W'($urandom);
    end else if (conv_q.size() == 0 || (conv_q[0].hold_off && text_q.size() != 0)) begin
      // nothing to send, or a drain point: idle with noise on the payload
      start    <= 1'b0;
      in_value <= $urandom;
      in_radix <= itoar_pkg::RADIX_W'($urandom);
    end else begin
      start    <= 1'b1;
      in_value <= conv_q[0].value;
      in_radix <= conv_q[0].radix;
      void'(conv_q.pop_front());
      burst_left = burst_left - 1;
      if (burst_left <= 0) begin
        burst_left = $urandom_range(1, 10);
        // a third of the bursts run straight into the next one
        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 15);
      end
    end
  end

  // monitor: takes requests and checks characters on the rising edge
  always @(posedge clk) begin
    char_beat_t want;
    item_taken <= rst_n && start && !busy;
    if (rst_n) begin
      // results on the ports belong to earlier transactions, so check before predicting
      if (out_valid) begin
        n_chars++;
        if (text_q.size() == 0) begin
          $error("unexpected character: code %h last %b bad_radix %b",
                 out_char_code, out_last, out_bad_radix);
          n_fail++;
        end else begin
          want = text_q.pop_front();
          if (out_char_code !== want.code) begin
            $error("char_code: expected %h, actual %h", want.code, out_char_code);
            n_fail++;
          end
          if (out_last !== want.last) begin
            $error("last: expected %b, actual %b", want.last, out_last);
            n_fail++;
          end
          if (out_bad_radix !== want.bad) begin
            $error("bad_radix: expected %b, actual %b", want.bad, out_bad_radix);
            n_fail++;
          end
        end
      end
      if (start && !busy) begin
        n_conv++;
        predict_text(in_value, in_radix);
      end
    end
  end

  function automatic void add_conv(input logic [31:0] v,
                                   input logic [itoar_pkg::RADIX_W-1:0] r,
                                   input logic h);
    conv_req_t req;
    req.value    = v;
    req.radix    = r;
    req.hold_off = h;
    conv_q.push_back(req);
  endfunction

  // random value: mixes full patterns, small numbers, negatives, single bits and single cleared bits
  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 4))
      0: return $urandom;
      1: return $urandom_range(0, 1000);
      2: return 32'd0 - $urandom_range(1, 100000);
      3: return {1'b1, 31'($urandom)};
      default: return ($urandom_range(0, 1) != 0) ? (32'd1 << $urandom_range(0, 31))
                                                  : ~(32'd1 << $urandom_range(0, 31));
    endcase
  endfunction

  function automatic logic [itoar_pkg::RADIX_W-1:0] pick_radix();
    if ($urandom_range(0, 9) == 0) return itoar_pkg::RADIX_W'($urandom_range(0, 63));
    if ($urandom_range(0, 3) == 0) return itoar_pkg::DEC_RADIX;
    return itoar_pkg::RADIX_W'($urandom_range(2, 36));
  endfunction

  initial begin
    // directed: zero, extremes, letter boundaries, every bad radix class
    add_conv(32'd0,          itoar_pkg::DEC_RADIX, 1'b0);
    add_conv(32'd0,          6'd2,                 1'b0);
    add_conv(32'h7fffffff,   itoar_pkg::DEC_RADIX, 1'b0);
    // most negative, magnitude formed unsigned
    add_conv(32'h80000000,   itoar_pkg::DEC_RADIX, 1'b0);
    add_conv(32'hffffffff,   itoar_pkg::DEC_RADIX, 1'b0);
    add_conv(32'hffffffff,   6'd2,                 1'b0);  // longest string, 32 digits
    add_conv(32'h80000000,   6'd2,                 1'b1);
    add_conv(32'hffffffff,   itoar_pkg::MAX_RADIX, 1'b0);
    add_conv(32'hffffffff,   6'd16,                1'b0);
    add_conv(32'd35,         itoar_pkg::MAX_RADIX, 1'b0);  // single 'z'
    add_conv(32'd36,         itoar_pkg::MAX_RADIX, 1'b0);
    add_conv(32'd9,          itoar_pkg::DEC_RADIX, 1'b0);
    add_conv(32'd10,         6'd11,                1'b0);  // single 'a'
    add_conv(32'd1,          6'd2,                 1'b0);
    add_conv(32'hdeadbeef,   6'd16,                1'b0);
    add_conv(32'hdeadbeef,   6'd8,                 1'b0);
    add_conv(32'd0 - 32'd12345, itoar_pkg::DEC_RADIX, 1'b0);
    add_conv(32'd12345,      6'd3,                 1'b0);
    add_conv(32'd12345,      6'd0,                 1'b0);  // radix below range
    add_conv(32'd7,          6'd1,                 1'b0);
    add_conv(32'hffffffff,   6'd37,                1'b0);  // radix just above range
    add_conv(32'h55555555,   6'd63,                1'b0);  // all radix bits set
    add_conv(32'h80000000,   6'd7,                 1'b1);
    // random part, with an occasional drain point
    repeat (100) add_conv(pick_value(), pick_radix(), $urandom_range(0, 24) == 0);

    // reset, released on a falling edge
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // all requests taken (start only moves on the falling edge), then all characters back
    while (conv_q.size() != 0 || start) @(posedge clk);
    while (text_q.size() != 0) @(negedge clk);
    // stray characters would show up within the worst-case conversion time
    repeat (200) @(negedge clk);

    if (text_q.size() != 0) begin
      $error("%0d expected characters never arrived", text_q.size());
      n_fail++;
    end

    $display("covered %0d conversions (%0d radix errors, %0d negative in base ten),",
             n_conv, n_bad, n_neg);
    $display("%0d characters checked, %0d mismatches", n_chars, n_fail);
    if (n_fail == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // watchdog
  initial begin
    #5_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule
